// File: hw/rtl/ptlru_pkg.sv
// ptlru_pkg: types and codes for the peer table with LRU replacement.
// Used by ptlru_cell and peer_table_lru_cache; no dependencies.
`default_nettype none
package ptlru_pkg;

  typedef enum logic [1:0] {
    KIND_SAVE   = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_CLEAR  = 2'd2,
    KIND_NONE   = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    OUT_UPDATED   = 3'd0,
    OUT_APPENDED  = 3'd1,
    OUT_EVICTED   = 3'd2,
    OUT_REMOVED   = 3'd3,
    OUT_NOT_FOUND = 3'd4,
    OUT_CLEARED   = 3'd5
  } outcome_e;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_NEXT,
    CELL_LOAD
  } cell_mode_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_APPLY
  } state_e;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] vpn_ip;
    logic [63:0] key_word0;
    logic [63:0] key_word1;
    logic [63:0] key_word2;
    logic [63:0] key_word3;
  } req_t;

  typedef struct packed {
    logic [2:0]  outcome;
    logic [5:0]  slot;
    logic [6:0]  entry_count;
    logic [31:0] displaced_ip;
  } res_t;

  typedef struct packed {
    logic [31:0] addr;
    logic [63:0] key_a;
    logic [63:0] key_b;
    logic [63:0] key_c;
    logic [63:0] key_d;
    logic [15:0] stamp;
  } entry_t;

endpackage
`default_nettype wire

// File: hw/rtl/ptlru_cell.sv
// ptlru_cell: one table entry of the peer table chain.
// Holds, takes its neighbor's entry, or loads a new one. Uses ptlru_pkg.
`default_nettype none
module ptlru_cell
  import ptlru_pkg::*;
(
  input  wire        clk_i,
  input  cell_mode_e mode_i,
  input  entry_t     load_i,
  input  entry_t     next_i,
  output entry_t     entry_o
);

  entry_t entry_q, entry_d;

  always_comb begin
    case (mode_i)
      CELL_NEXT: entry_d = next_i;
      CELL_LOAD: entry_d = load_i;
      default:   entry_d = entry_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule
`default_nettype wire

// File: hw/rtl/peer_table_lru_cache.sv
// peer_table_lru_cache: peer table with LRU replacement, built as a rotating chain of cells.
// Depends on ptlru_pkg and ptlru_cell.
//
// Usage: drive req_i and raise start while busy is low; the item is taken at that edge.
// A save or remove rotates the whole chain once past cell 0 in ST_SCAN to find the first
// match and the oldest stamp, then writes or compacts the cells in ST_APPLY. Its result is
// registered from ST_APPLY, and the next item can be taken at the edge that ends the result
// cycle; the scan length is set by the chain depth.
// A clear gives its result in the cycle after acceptance; kind 3 gives none.
// For a save or remove, busy is high from the cycle after acceptance until the apply
// cycle ends; a new item may be taken while the previous result is on the ports.
// done_o marks each result for one cycle and res_o holds it; the receiver cannot stall.
// Reset empties the table and zeroes the use clock; entry contents are not cleared.
`default_nettype none
module peer_table_lru_cache
  import ptlru_pkg::*;
#(
  parameter int MAX_ENTRIES = 64
) (
  input  wire  clk_i,
  input  wire  rst_ni,
  input  wire  start,
  input  req_t req_i,
  output logic busy,
  output logic done_o,
  output res_t res_o
);

  localparam int IdxW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CntW = $clog2(MAX_ENTRIES + 1);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(MAX_ENTRIES - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(MAX_ENTRIES);

  state_e          state_q, state_d;
  req_t            req_q;
  logic [15:0]     clock_q, clock_d;
  logic [CntW-1:0] count_q, count_d;
  logic [IdxW-1:0] idx_q;
  logic            hit_q;
  logic [IdxW-1:0] hit_idx_q;
  logic [31:0]     hit_addr_q;
  logic [IdxW-1:0] min_idx_q;
  logic [15:0]     min_stamp_q;
  logic [31:0]     min_addr_q;
  res_t            res_q, res_d;
  logic            done_q, done_d;

  entry_t     cell_out [MAX_ENTRIES];
  cell_mode_e mode     [MAX_ENTRIES];
  entry_t     new_entry;
  entry_t     head;

  logic            accept;
  logic            in_range;
  logic            head_hit;
  logic            load_en;
  logic            shift_en;
  logic [IdxW-1:0] tgt;

  assign accept = start && (state_q == ST_IDLE);
  assign busy   = (state_q != ST_IDLE);
  assign head   = cell_out[0];

  assign new_entry = '{addr:  req_q.vpn_ip,
                       key_a: req_q.key_word0,
                       key_b: req_q.key_word1,
                       key_c: req_q.key_word2,
                       key_d: req_q.key_word3,
                       stamp: clock_q};

  assign in_range = CntW'(idx_q) < count_q;
  assign head_hit = (head.key_a == req_q.key_word0 && head.key_b == req_q.key_word1 &&
                     head.key_c == req_q.key_word2 && head.key_d == req_q.key_word3) ||
                    (kind_e'(req_q.kind) == KIND_SAVE && head.addr == req_q.vpn_ip);

  for (genvar j = 0; j < MAX_ENTRIES; j++) begin : g_cell
    ptlru_cell u_cell (
      .clk_i   (clk_i),
      .mode_i  (mode[j]),
      .load_i  (new_entry),
      .next_i  (cell_out[(j + 1) % MAX_ENTRIES]),
      .entry_o (cell_out[j])
    );
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && (kind_e'(req_i.kind) == KIND_SAVE ||
                       kind_e'(req_i.kind) == KIND_REMOVE)) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (idx_q == LastIdx) begin
          state_d = ST_APPLY;
        end
      end
      ST_APPLY: state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    clock_d  = clock_q;
    count_d  = count_q;
    res_d    = res_q;
    done_d   = 1'b0;
    load_en  = 1'b0;
    shift_en = 1'b0;
    tgt      = '0;
    for (int j = 0; j < MAX_ENTRIES; j++) begin
      mode[j] = CELL_HOLD;
    end
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (kind_e'(req_i.kind))
            KIND_SAVE: clock_d = clock_q + 16'd1;
            KIND_CLEAR: begin
              clock_d = '0;
              count_d = '0;
              res_d   = '{outcome: OUT_CLEARED, slot: '0, entry_count: '0,
                          displaced_ip: '0};
              done_d  = 1'b1;
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        for (int j = 0; j < MAX_ENTRIES; j++) begin
          mode[j] = CELL_NEXT;
        end
      end
      ST_APPLY: begin
        done_d = 1'b1;
        res_d.displaced_ip = '0;
        if (kind_e'(req_q.kind) == KIND_SAVE) begin
          load_en = 1'b1;
          if (hit_q) begin
            tgt           = hit_idx_q;
            res_d.outcome = OUT_UPDATED;
          end else if (count_q < FullCnt) begin
            tgt           = IdxW'(count_q);
            count_d       = count_q + CntW'(1);
            res_d.outcome = OUT_APPENDED;
          end else begin
            tgt                = min_idx_q;
            res_d.outcome      = OUT_EVICTED;
            res_d.displaced_ip = min_addr_q;
          end
        end else if (hit_q) begin
          shift_en           = 1'b1;
          tgt                = hit_idx_q;
          count_d            = count_q - CntW'(1);
          res_d.outcome      = OUT_REMOVED;
          res_d.displaced_ip = hit_addr_q;
        end else begin
          res_d.outcome = OUT_NOT_FOUND;
        end
        res_d.slot        = 6'(tgt);
        res_d.entry_count = 7'(count_d);
        for (int j = 0; j < MAX_ENTRIES; j++) begin
          if (load_en && tgt == IdxW'(j)) begin
            mode[j] = CELL_LOAD;
          end else if (shift_en && IdxW'(j) >= tgt) begin
            mode[j] = CELL_NEXT;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      clock_q <= '0;
      count_q <= '0;
      done_q  <= 1'b0;
      idx_q   <= '0;
      hit_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      clock_q <= clock_d;
      count_q <= count_d;
      done_q  <= done_d;
      if (accept) begin
        idx_q <= '0;
        hit_q <= 1'b0;
      end else if (state_q == ST_SCAN) begin
        idx_q <= idx_q + IdxW'(1);
        if (in_range && !hit_q && head_hit) begin
          hit_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (accept) begin
      req_q <= req_i;
    end
    if (state_q == ST_SCAN && in_range) begin
      if (!hit_q && head_hit) begin
        hit_idx_q  <= idx_q;
        hit_addr_q <= head.addr;
      end
      if (idx_q == '0 || head.stamp < min_stamp_q) begin
        min_idx_q   <= idx_q;
        min_stamp_q <= head.stamp;
        min_addr_q  <= head.addr;
      end
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule
`default_nettype wire

// File: sim/peer_table_lru_cache_tb.sv
// peer_table_lru_cache_tb: self-checking testbench for the peer table with LRU replacement.
// Depends on ptlru_pkg and peer_table_lru_cache; drives a directed table, then random items,
// and checks every result against a row's expected result or a predictor of table contents.
`timescale 1ns / 1ps
`default_nettype none
module peer_table_lru_cache_tb;
  import ptlru_pkg::*;

  localparam int MAX_ENTRIES  = 64;
  localparam int RANDOM_ITEMS = 1400;
  localparam int IDLE_LIMIT   = 4000;

  typedef struct {
    kind_e        kind;
    logic [31:0]  ip;
    logic [255:0] key;
    bit           typed;
    res_t         res;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  req_t req_i = '0;
  logic busy;
  logic done_o;
  res_t res_o;

  peer_table_lru_cache #(.MAX_ENTRIES(MAX_ENTRIES)) dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .req_i(req_i),
    .busy(busy), .done_o(done_o), .res_o(res_o)
  );

  always #5 clk_i = ~clk_i;

  logic [31:0]  peer_addr[MAX_ENTRIES];
  logic [255:0] peer_key[MAX_ENTRIES];
  logic [15:0]  peer_stamp[MAX_ENTRIES];
  logic [15:0]  use_clock;
  int           peer_count;

  res_t      pending_results[$];
  stim_row_t stim_rows[$];
  int        mismatches;
  int        outcome_seen[6];
  int        idle_cycles;

  function automatic bit predict_peer_op(input req_t r, output res_t e);
    logic [255:0] k;
    int hit;
    int oldest;
    k = {r.key_word0, r.key_word1, r.key_word2, r.key_word3};
    e = '0;
    hit = -1;
    case (r.kind)
      KIND_SAVE: begin
        use_clock = use_clock + 16'd1;
        for (int i = 0; i < peer_count; i++)
          if (hit < 0 && (peer_addr[i] == r.vpn_ip || peer_key[i] == k)) hit = i;
        if (hit >= 0) begin
          e.outcome = OUT_UPDATED;
        end else if (peer_count < MAX_ENTRIES) begin
          hit = peer_count;
          peer_count++;
          e.outcome = OUT_APPENDED;
        end else begin
          oldest = 0;
          for (int i = 1; i < peer_count; i++)
            if (peer_stamp[i] < peer_stamp[oldest]) oldest = i;
          hit = oldest;
          e.displaced_ip = peer_addr[oldest];
          e.outcome = OUT_EVICTED;
        end
        peer_addr[hit] = r.vpn_ip;
        peer_key[hit] = k;
        peer_stamp[hit] = use_clock;
        e.slot = hit[5:0];
      end
      KIND_REMOVE: begin
        for (int i = 0; i < peer_count; i++)
          if (hit < 0 && peer_key[i] == k) hit = i;
        if (hit >= 0) begin
          e.displaced_ip = peer_addr[hit];
          e.slot = hit[5:0];
          for (int j = hit; j + 1 < peer_count; j++) begin
            peer_addr[j] = peer_addr[j + 1];
            peer_key[j] = peer_key[j + 1];
            peer_stamp[j] = peer_stamp[j + 1];
          end
          peer_count--;
          e.outcome = OUT_REMOVED;
        end else begin
          e.outcome = OUT_NOT_FOUND;
        end
      end
      KIND_CLEAR: begin
        peer_count = 0;
        use_clock = '0;
        e.outcome = OUT_CLEARED;
      end
      default: return 1'b0;
    endcase
    e.entry_count = peer_count[6:0];
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
    mismatches++;
  endtask

  task automatic idle_gap();
    int r;
    int n;
    r = $urandom_range(0, 9);
    n = (r < 6) ? 0 : (r < 9) ? $urandom_range(1, 3) : $urandom_range(20, 60);
    if (n > 0) begin
      start = 1'b0;
      repeat (n) @(negedge clk_i);
    end
  endtask

  task automatic issue_item(input req_t r, input bit typed, input res_t want);
    res_t e;
    bit   has;
    req_i = r;
    start = 1'b1;
    while (busy) @(negedge clk_i);
    @(posedge clk_i);
    has = predict_peer_op(r, e);
    if (has) pending_results.push_back(typed ? want : e);
    @(negedge clk_i);
    start = 1'b0;
    idle_gap();
  endtask

  task automatic add_row(input kind_e kd, input logic [31:0] ip, input logic [255:0] key,
                         input bit typed, input res_t res);
    stim_row_t row;
    row.kind = kd;
    row.ip = ip;
    row.key = key;
    row.typed = typed;
    row.res = res;
    stim_rows.push_back(row);
  endtask

  function automatic logic [255:0] fresh_key();
    return {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", 32'(res_o.outcome), 32'd0);
      end else begin
        res_t w;
        w = pending_results.pop_front();
        if (res_o.outcome != w.outcome)
          report_mismatch("outcome", 32'(res_o.outcome), 32'(w.outcome));
        if (res_o.slot != w.slot) report_mismatch("slot", 32'(res_o.slot), 32'(w.slot));
        if (res_o.entry_count != w.entry_count)
          report_mismatch("entry_count", 32'(res_o.entry_count), 32'(w.entry_count));
        if (res_o.displaced_ip != w.displaced_ip)
          report_mismatch("displaced_ip", res_o.displaced_ip, w.displaced_ip);
        if (res_o.outcome < 6) outcome_seen[res_o.outcome]++;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start && !busy) || done_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    logic [255:0] ones;
    logic [255:0] k;
    logic [31:0]  ip;
    req_t r;
    int   c;
    int   pick;
    ones = '1;
    idle_cycles = 0;
    mismatches = 0;
    peer_count = 0;
    use_clock = '0;
    add_row(KIND_CLEAR, 32'h0, '0, 1, '{OUT_CLEARED, 6'd0, 7'd0, 32'h0});
    add_row(KIND_REMOVE, 32'h0, '0, 1, '{OUT_NOT_FOUND, 6'd0, 7'd0, 32'h0});
    add_row(KIND_SAVE, 32'h0, '0, 1, '{OUT_APPENDED, 6'd0, 7'd1, 32'h0});
    add_row(KIND_SAVE, 32'hffffffff, ones, 1, '{OUT_APPENDED, 6'd1, 7'd2, 32'h0});
    add_row(KIND_NONE, 32'h5, ones, 0, '0);
    add_row(KIND_SAVE, 32'hffffffff, 256'h1234, 1, '{OUT_UPDATED, 6'd1, 7'd2, 32'h0});
    add_row(KIND_SAVE, 32'h7, '0, 1, '{OUT_UPDATED, 6'd0, 7'd2, 32'h0});
    add_row(KIND_SAVE, 32'h8, fresh_key(), 0, '0);
    add_row(KIND_REMOVE, 32'h0, 256'h1234, 1, '{OUT_REMOVED, 6'd1, 7'd2, 32'hffffffff});
    add_row(KIND_REMOVE, 32'h0, ones, 1, '{OUT_NOT_FOUND, 6'd0, 7'd2, 32'h0});
    add_row(KIND_SAVE, 32'h9, {4{64'h5555555555555555}}, 0, '0);
    add_row(KIND_REMOVE, 32'h0, '0, 0, '0);
    add_row(KIND_CLEAR, 32'hffffffff, ones, 1, '{OUT_CLEARED, 6'd0, 7'd0, 32'h0});
    add_row(KIND_REMOVE, 32'h0, '0, 1, '{OUT_NOT_FOUND, 6'd0, 7'd0, 32'h0});
    add_row(KIND_SAVE, 32'haaaaaaaa, {4{64'haaaaaaaaaaaaaaaa}}, 1,
            '{OUT_APPENDED, 6'd0, 7'd1, 32'h0});

    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (stim_rows[i]) begin
      r = '0;
      r.kind = stim_rows[i].kind;
      r.vpn_ip = stim_rows[i].ip;
      {r.key_word0, r.key_word1, r.key_word2, r.key_word3} = stim_rows[i].key;
      issue_item(r, stim_rows[i].typed, stim_rows[i].res);
    end

    start = 1'b0;
    wait (pending_results.size() == 0);
    @(negedge clk_i);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      c = $urandom_range(0, 999);
      ip = $urandom;
      k = fresh_key();
      r = '0;
      if (c < 7) begin
        r.kind = KIND_CLEAR;
      end else if (c < 25) begin
        r.kind = KIND_NONE;
      end else if (c < 230) begin
        r.kind = KIND_REMOVE;
        if (peer_count > 0 && $urandom_range(0, 3) != 0)
          k = peer_key[$urandom_range(0, peer_count - 1)];
      end else begin
        r.kind = KIND_SAVE;
        if (peer_count > 0 && $urandom_range(0, 2) == 0) begin
          pick = $urandom_range(0, peer_count - 1);
          case ($urandom_range(0, 2))
            0: ip = peer_addr[pick];
            1: k = peer_key[pick];
            default: begin
              ip = peer_addr[pick];
              k = peer_key[pick];
            end
          endcase
        end
      end
      r.vpn_ip = ip;
      {r.key_word0, r.key_word1, r.key_word2, r.key_word3} = k;
      issue_item(r, 0, '0);
    end

    start = 1'b0;
    wait (pending_results.size() == 0);
    repeat (MAX_ENTRIES + 10) @(posedge clk_i);
    $display("covered %0d updates, %0d appends, %0d evictions", outcome_seen[OUT_UPDATED],
             outcome_seen[OUT_APPENDED], outcome_seen[OUT_EVICTED]);
    $display("covered %0d removes, %0d misses, %0d clears; %0d mismatches",
             outcome_seen[OUT_REMOVED], outcome_seen[OUT_NOT_FOUND],
             outcome_seen[OUT_CLEARED], mismatches);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire
